### sv/triangle_depth_rasterizer_defines.svh
// ---------------------------------------------------------------------------
// Triangle depth rasterizer assertion macros
// Shared concurrent property shorthands, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_DEPTH_RASTERIZER_DEFINES_SVH
`define TRIANGLE_DEPTH_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define TDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdr assertion failed");

// Next-cycle implication.
`define TDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdr assertion failed");

`endif

### sv/tdr_pkg.sv
// ---------------------------------------------------------------------------
// Triangle depth rasterizer package
// Sizes, codes and shared types for the rasterizer and its units.
// ---------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);

  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 13;
  localparam int ZIN_W      = 16;
  localparam int COLOR_W    = 24;
  localparam int IDX_W      = 19;
  localparam int COUNT_W    = 20;

  localparam int DIFF_W     = 15;
  localparam int PROD_W     = 30;
  localparam int EDGE_W     = 31;
  localparam int ZPROD_W    = 47;
  localparam int NUM_W      = 49;
  localparam int QUO_W      = 17;
  localparam int DEN_W      = 30;
  localparam int DCNT_W     = $clog2(QUO_W);
  localparam int ZST_W      = 17;

  localparam logic [ZST_W-1:0] DEPTH_MAX = ZST_W'(65535);
  localparam int SHADE_BASE = 18;
  localparam int SHADE_SPAN = 18;
  localparam int BLUE_LIFT  = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_CLR_DIV, ST_CLR_WAIT, ST_CLR_FILL,
    ST_TRI_AREA, ST_TRI_SETUP,
    ST_PX_EDGE, ST_PX_SUM, ST_PX_TEST, ST_PX_MUL, ST_PX_ADD, ST_PX_DIV, ST_PX_CMP,
    ST_RD_ISSUE, ST_RD_DATA,
    ST_DONE
  } state_e;

  // Divider handshake toward the sequencer.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/triangle_depth_rasterizer.sv
// Operation: a read issues the store read and registers the returned colour; a clear
//   runs the divider for each row's shade, then fills the row; a triangle walks its box,
//   and only covered pixels get the depth multiply, the divide and the depth test.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: after rst_ni releases, a clearing pass writes all 524288 store entries,
//   one per cycle, with in_ready_o low; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// Triangle depth rasterizer
// Sequencer around a colour store and a depth store: clear, draw, read.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_depth_rasterizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tdr_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] a_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] a_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   a_z_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] b_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] b_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   b_z_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] c_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] c_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   c_z_i,
  input  wire logic [tdr_pkg::COLOR_W-1:0]   tri_color_i,
  input  wire logic [tdr_pkg::IDX_W-1:0]     pixel_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tdr_pkg::COUNT_W-1:0]        drawn_count_o,
  output logic [tdr_pkg::COLOR_W-1:0]        pixel_color_o
);

  import tdr_pkg::*;

  // ---------------- configuration ----------------
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    priority if (width_q == '0)                      w_eff = WIDTH_W'(1);
    else if (width_q > WIDTH_W'(MAX_WIDTH))          w_eff = WIDTH_W'(MAX_WIDTH);
    else                                             w_eff = width_q;
    priority if (height_q == '0)                     h_eff = HEIGHT_W'(1);
    else if (height_q > HEIGHT_W'(MAX_HEIGHT))       h_eff = HEIGHT_W'(MAX_HEIGHT);
    else                                             h_eff = height_q;
  end

  // ---------------- state and datapath registers ----------------
  state_e state_q, state_d;
  logic   out_valid_q;
  logic [ADDR_W-1:0]  addr_q;       // sweep / clear / read address
  logic [ADDR_W-1:0]  row_base_q;   // y * width during the box walk
  logic [X_W-1:0]     x_q, x0_q, x1_q;
  logic [Y_W-1:0]     y_q, y1_q;
  logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [ZIN_W-1:0]   az_q, bz_q, cz_q;
  logic [COLOR_W-1:0] tri_col_q, clr_col_q;
  logic signed [PROD_W-1:0]  pr_q [6];
  logic signed [EDGE_W-1:0]  area_q, e0_q, e1_q, e2_q;
  logic signed [ZPROD_W-1:0] zp_q [3];
  logic                      num_neg_q;
  logic signed [ZST_W-1:0]   z_q;
  logic [COUNT_W-1:0] drawn_q, res_drawn_q, drawn_out_q;
  logic [COLOR_W-1:0] res_pix_q, pix_out_q;

  // ---------------- stores ----------------
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [COLOR_W-1:0] col_wdata, col_rdata;
  logic [ZST_W-1:0]   dep_wdata, dep_rdata;

  tdr_ram #(.DATA_W(COLOR_W), .ADDR_W(ADDR_W)) u_color (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(col_wdata),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(col_rdata)
  );

  tdr_ram #(.DATA_W(ZST_W), .ADDR_W(ADDR_W)) u_depth (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(dep_wdata),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(dep_rdata)
  );

  // ---------------- shared divider ----------------
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  div_rsp_t         div_rsp;

  tdr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .rsp_o(div_rsp)
  );

  // ---------------- edge products ----------------
  // In the area step the sample point is vertex c, so edge 2 gives the area.
  logic signed [DIFF_W-1:0] px, py;
  logic signed [DIFF_W-1:0] vax, vay, vbx, vby, vcx, vcy;
  logic signed [PROD_W-1:0] pr_d [6];

  always_comb begin
    vax = DIFF_W'(ax_q);
    vay = DIFF_W'(ay_q);
    vbx = DIFF_W'(bx_q);
    vby = DIFF_W'(by_q);
    vcx = DIFF_W'(cx_q);
    vcy = DIFF_W'(cy_q);
    if (state_q == ST_TRI_AREA) begin
      px = vcx;
      py = vcy;
    end else begin
      px = DIFF_W'({1'b0, x_q});
      py = DIFF_W'({1'b0, y_q});
    end
    pr_d[0] = PROD_W'(DIFF_W'(px - vbx)) * PROD_W'(DIFF_W'(vcy - vby));
    pr_d[1] = PROD_W'(DIFF_W'(py - vby)) * PROD_W'(DIFF_W'(vcx - vbx));
    pr_d[2] = PROD_W'(DIFF_W'(px - vcx)) * PROD_W'(DIFF_W'(vay - vcy));
    pr_d[3] = PROD_W'(DIFF_W'(py - vcy)) * PROD_W'(DIFF_W'(vax - vcx));
    pr_d[4] = PROD_W'(DIFF_W'(px - vax)) * PROD_W'(DIFF_W'(vby - vay));
    pr_d[5] = PROD_W'(DIFF_W'(py - vay)) * PROD_W'(DIFF_W'(vbx - vax));
  end

  // ---------------- bounding box ----------------
  function automatic logic signed [DIFF_W-1:0] min3(
    input logic signed [DIFF_W-1:0] a, b, c);
    logic signed [DIFF_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [DIFF_W-1:0] max3(
    input logic signed [DIFF_W-1:0] a, b, c);
    logic signed [DIFF_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [DIFF_W-1:0] clampv(
    input logic signed [DIFF_W-1:0] v, hi);
    logic signed [DIFF_W-1:0] r;
    priority if (v < 0) r = '0;
    else if (v > hi)    r = hi;
    else                r = v;
    return r;
  endfunction

  logic signed [EDGE_W-1:0] area_d;
  logic signed [DIFF_W-1:0] xhi, yhi, bx0, bx1, by0, by1;

  always_comb begin
    area_d = EDGE_W'(pr_q[4]) - EDGE_W'(pr_q[5]);
    xhi = DIFF_W'(w_eff) - DIFF_W'(1);
    yhi = DIFF_W'(h_eff) - DIFF_W'(1);
    bx0 = clampv(min3(vax, vbx, vcx), xhi);
    bx1 = clampv(max3(vax, vbx, vcx) + DIFF_W'(1), xhi);
    by0 = clampv(min3(vay, vby, vcy), yhi);
    by1 = clampv(max3(vay, vby, vcy) + DIFF_W'(1), yhi);
  end

  // ---------------- depth interpolation ----------------
  logic signed [NUM_W-1:0] num_sum;
  logic [NUM_W-1:0]        num_mag;
  logic [DEN_W-1:0]        area_mag;
  logic signed [ZST_W-1:0] z_d;

  always_comb begin
    num_sum  = NUM_W'(zp_q[0]) + NUM_W'(zp_q[1]) + NUM_W'(zp_q[2]);
    num_mag  = num_sum[NUM_W-1] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
    area_mag = DEN_W'(-area_q);
    // area is negative, so the quotient takes the opposite sign of the sum
    z_d = num_neg_q ? ZST_W'(div_rsp.quo) : ZST_W'(-ZST_W'(div_rsp.quo));
  end

  // ---------------- clear colour ----------------
  logic [7:0] shade;
  assign shade = 8'(SHADE_BASE) + 8'(div_rsp.quo);

  // ---------------- walk control ----------------
  logic row_end, box_end, covered, deeper, pix_addr_sel;
  logic [ADDR_W-1:0] pix_addr;

  assign pix_addr = row_base_q + ADDR_W'(x_q);
  assign row_end  = (x_q == x1_q);
  assign box_end  = row_end && (y_q == y1_q);
  assign covered  = (e0_q <= 0) && (e1_q <= 0) && (e2_q <= 0);
  assign deeper   = z_q < $signed(dep_rdata);

  // ---------------- next state and store controls ----------------
  logic in_acc, out_load;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = addr_q;
    col_wdata    = '0;
    dep_wdata    = DEPTH_MAX;
    div_start    = 1'b0;
    div_num      = NUM_W'(y_q) * NUM_W'(SHADE_SPAN);
    div_den      = DEN_W'(h_eff);
    pix_addr_sel = 1'b1;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (addr_q == ADDR_W'(STORE_SIZE - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_CLEAR: state_d = ST_CLR_DIV;
            KIND_TRI:   state_d = ST_TRI_AREA;
            KIND_READ:  state_d = ST_RD_ISSUE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR_DIV: begin
        div_start = 1'b1;
        state_d   = ST_CLR_WAIT;
      end
      ST_CLR_WAIT: begin
        if (div_rsp.done) state_d = ST_CLR_FILL;
      end
      ST_CLR_FILL: begin
        mem_we    = 1'b1;
        col_wdata = clr_col_q;
        if (x_q == X_W'(w_eff - 1'b1)) begin
          state_d = (y_q == Y_W'(h_eff - 1'b1)) ? ST_DONE : ST_CLR_DIV;
        end
      end
      ST_TRI_AREA:  state_d = ST_TRI_SETUP;
      ST_TRI_SETUP: state_d = (area_d >= 0) ? ST_DONE : ST_PX_EDGE;
      ST_PX_EDGE:   state_d = ST_PX_SUM;
      ST_PX_SUM:    state_d = ST_PX_TEST;
      ST_PX_TEST: begin
        priority if (covered) state_d = ST_PX_MUL;
        else if (box_end)     state_d = ST_DONE;
        else                  state_d = ST_PX_EDGE;
      end
      ST_PX_MUL: state_d = ST_PX_ADD;
      ST_PX_ADD: begin
        div_start = 1'b1;
        div_num   = num_mag;
        div_den   = area_mag;
        mem_re    = 1'b1;
        state_d   = ST_PX_DIV;
      end
      ST_PX_DIV: begin
        if (div_rsp.done) state_d = ST_PX_CMP;
      end
      ST_PX_CMP: begin
        mem_waddr = pix_addr;
        col_wdata = tri_col_q;
        dep_wdata = z_q;
        mem_we    = deeper;
        state_d   = box_end ? ST_DONE : ST_PX_EDGE;
      end
      ST_RD_ISSUE: begin
        mem_re       = 1'b1;
        pix_addr_sel = 1'b0;
        state_d      = ST_RD_DATA;
      end
      ST_RD_DATA: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign mem_raddr = pix_addr_sel ? pix_addr : addr_q;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      width_q     <= WIDTH_W'(640);
      height_q    <= HEIGHT_W'(360);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      // advance the sweep or clear address, or load it when a request is accepted
      priority if (state_q == ST_INIT || state_q == ST_CLR_FILL) begin
        addr_q <= addr_q + 1'b1;
      end else if (in_acc) begin
        addr_q <= (kind_i == KIND_READ) ? ADDR_W'(pixel_index_i) : '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= a_x_i;  ay_q <= a_y_i;  az_q <= a_z_i;
      bx_q <= b_x_i;  by_q <= b_y_i;  bz_q <= b_z_i;
      cx_q <= c_x_i;  cy_q <= c_y_i;  cz_q <= c_z_i;
      tri_col_q   <= tri_color_i;
      x_q         <= '0;
      y_q         <= '0;
      drawn_q     <= '0;
      res_drawn_q <= '0;
      res_pix_q   <= '0;
    end
    if (state_q == ST_TRI_AREA || state_q == ST_PX_EDGE) begin
      for (int i = 0; i < 6; i++) pr_q[i] <= pr_d[i];
    end
    if (state_q == ST_CLR_WAIT && div_rsp.done) begin
      clr_col_q <= {shade, shade, 8'(shade + 8'(BLUE_LIFT))};
    end
    if (state_q == ST_CLR_FILL) begin
      if (x_q == X_W'(w_eff - 1'b1)) begin
        x_q <= '0;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
    if (state_q == ST_TRI_SETUP) begin
      area_q     <= area_d;
      x0_q       <= X_W'(bx0);
      x1_q       <= X_W'(bx1);
      x_q        <= X_W'(bx0);
      y_q        <= Y_W'(by0);
      y1_q       <= Y_W'(by1);
      row_base_q <= ADDR_W'(by0[Y_W-1:0]) * ADDR_W'(w_eff);
    end
    if (state_q == ST_PX_SUM) begin
      e0_q <= EDGE_W'(pr_q[0]) - EDGE_W'(pr_q[1]);
      e1_q <= EDGE_W'(pr_q[2]) - EDGE_W'(pr_q[3]);
      e2_q <= EDGE_W'(pr_q[4]) - EDGE_W'(pr_q[5]);
    end
    if (state_q == ST_PX_MUL) begin
      zp_q[0] <= ZPROD_W'(e0_q) * ZPROD_W'(az_q);
      zp_q[1] <= ZPROD_W'(e1_q) * ZPROD_W'(bz_q);
      zp_q[2] <= ZPROD_W'(e2_q) * ZPROD_W'(cz_q);
    end
    if (state_q == ST_PX_ADD) num_neg_q <= num_sum[NUM_W-1];
    if (state_q == ST_PX_DIV && div_rsp.done) z_q <= z_d;
    if (state_q == ST_PX_CMP && deeper) drawn_q <= drawn_q + 1'b1;
    // step to the next pixel of the box
    if ((state_q == ST_PX_TEST && !covered) || state_q == ST_PX_CMP) begin
      if (row_end) begin
        x_q        <= x0_q;
        y_q        <= y_q + 1'b1;
        row_base_q <= row_base_q + ADDR_W'(w_eff);
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
    if ((state_q == ST_PX_TEST && !covered && box_end) ||
        (state_q == ST_PX_CMP && box_end)) begin
      res_drawn_q <= (state_q == ST_PX_CMP && deeper) ? drawn_q + 1'b1 : drawn_q;
    end
    if (state_q == ST_RD_DATA) res_pix_q <= col_rdata;
    if (out_load) begin
      drawn_out_q <= res_drawn_q;
      pix_out_q   <= res_pix_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drawn_count_o = drawn_out_q;
  assign pixel_color_o = pix_out_q;

endmodule

`default_nettype wire

### sv/tdr_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tdr_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/tdr_div.sv
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit a cycle, for quotients below 2^QUO_W.
// ---------------------------------------------------------------------------
`default_nettype none

module tdr_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [tdr_pkg::NUM_W-1:0] num_i,
  input  wire logic [tdr_pkg::DEN_W-1:0] den_i,
  output tdr_pkg::div_rsp_t              rsp_o
);

  import tdr_pkg::*;

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [QUO_W-1:0]  low_q, quo_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              run_q, done_q;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DCNT_W'(QUO_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // quotient fits QUO_W bits, so the upper part is already below den
      rem_q <= DEN_W'(num_i >> QUO_W);
      low_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

### sv/tdr_checker.sv
// ---------------------------------------------------------------------------
// Triangle depth rasterizer port checker
// Watches the ports of the top level over time; bound to every instance.
// ---------------------------------------------------------------------------
`default_nettype none
`include "triangle_depth_rasterizer_defines.svh"

module tdr_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_o,
  input  wire logic [tdr_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] a_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] a_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   a_z_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] b_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] b_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   b_z_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] c_x_i,
  input  wire logic signed [tdr_pkg::COORD_W-1:0] c_y_i,
  input  wire logic signed [tdr_pkg::ZIN_W-1:0]   c_z_i,
  input  wire logic [tdr_pkg::COLOR_W-1:0]   tri_color_i,
  input  wire logic [tdr_pkg::IDX_W-1:0]     pixel_index_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic [tdr_pkg::COUNT_W-1:0]   drawn_count_o,
  input  wire logic [tdr_pkg::COLOR_W-1:0]   pixel_color_o
);

  // A stalled result keeps its payload.
  `TDR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(drawn_count_o) && $stable(pixel_color_o))

  // One request at a time: ready drops right after an accept.
  `TDR_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  // A result carries a count or a colour, never both.
  `TDR_ASSERT_NOW(a_one_field, out_valid_o, drawn_count_o == '0 || pixel_color_o == '0)

  // A new result appears only after the request that caused it has left the input.
  `TDR_ASSERT_NOW(a_no_early_result, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind triangle_depth_rasterizer tdr_checker u_tdr_checker (.*);

`default_nettype wire
